FILE: src/ufpp_pkg.sv
// Shared types, constants and codes for the USB feedback packet pacer.
`timescale 1ns / 1ps
package ufpp_pkg;

  // Fixed-point layout of the rate estimate and fraction accumulator.
  localparam int FRAC_BITS   = 16;
  localparam int EST_W       = 27;
  localparam int NOM_W       = 26;
  localparam int BPF_W       = 7;
  localparam int MPB_W       = 16;
  localparam int SUM_W       = EST_W + 1;
  localparam int SMP_W       = SUM_W - FRAC_BITS;
  localparam int BYTES_W     = SMP_W + BPF_W;
  localparam int OUT_SMP_W   = 11;
  localparam int OUT_BYTES_W = 17;
  localparam int AVAIL_W     = 17;
  localparam int CMD_W       = 2;
  localparam int FB_DATA_W   = 32;
  localparam int FB_LEN_W    = 3;
  localparam int STATUS_W    = 3;
  localparam int SAMPLES_MAX = 2047;

  // Realignment of feedback values to FRAC_BITS fraction bits.
  localparam int HS_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int HS_SHR = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam int FS_SHL = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
  localparam int FS_SHR = (FRAC_BITS >= 14) ? 0 : 14 - FRAC_BITS;
  localparam int MEAS_W = FB_DATA_W + FS_SHL;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NOM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SPEED_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET      = 2'd3;

  localparam logic [NOM_W-1:0] NOM_RESET = 26'd3145728;
  localparam logic [EST_W-1:0] EST_RESET = 27'd3145728;
  localparam logic [BPF_W-1:0] BPF_RESET = 7'd4;
  localparam logic [MPB_W-1:0] MPB_RESET = 16'd192;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_PACKET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FEEDBACK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FB_APPLIED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FB_IGNORED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RESTARTED  = 3'd5;

  typedef struct packed {
    logic [NOM_W-1:0] nominal_rate;
    logic             high_speed_mode;
    logic [BPF_W-1:0] frame_size;
    logic [MPB_W-1:0] max_packet_len;
  } cfg_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] fraction_accumulator;
    logic [EST_W-1:0]     rate_estimate;
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [FB_DATA_W-1:0] feedback_data;
    logic [FB_LEN_W-1:0]  feedback_length;
    logic [AVAIL_W-1:0]   available_bytes;
  } item_t;

  typedef struct packed {
    logic [OUT_SMP_W-1:0]   packet_samples;
    logic [OUT_BYTES_W-1:0] packet_len;
    logic [STATUS_W-1:0]    status;
    logic [EST_W-1:0]       rate_estimate_out;
  } result_t;

endpackage

FILE: src/ufpp_step.sv
// Single-pass pacing step: one command against the current pacing state.
`timescale 1ns / 1ps
module ufpp_step (
  input  ufpp_pkg::cfg_t    cfg,
  input  ufpp_pkg::state_t  state,
  input  ufpp_pkg::item_t   item,
  output ufpp_pkg::state_t  state_nxt,
  output ufpp_pkg::result_t result
);

  // packet path
  logic [ufpp_pkg::SUM_W-1:0]   sum;
  logic [ufpp_pkg::SMP_W-1:0]   samples_raw;
  logic [ufpp_pkg::SMP_W-1:0]   samples;
  logic [ufpp_pkg::BYTES_W-1:0] bytes;
  logic                         oversize;
  logic                         short_in;

  // feedback path
  logic                          use_hs;
  logic [ufpp_pkg::MEAS_W-1:0]   meas_hs;
  logic [ufpp_pkg::MEAS_W-1:0]   meas_fs;
  logic [ufpp_pkg::MEAS_W-1:0]   measured;
  logic [ufpp_pkg::EST_W-1:0]    nom_ext;
  logic [ufpp_pkg::EST_W-1:0]    slack;
  logic [ufpp_pkg::EST_W-1:0]    lo;
  logic [ufpp_pkg::EST_W-1:0]    hi;
  logic [ufpp_pkg::EST_W-1:0]    clamped;
  logic [ufpp_pkg::EST_W+2:0]    blend;

  always_comb begin
    sum = {1'b0, state.rate_estimate} +
          ufpp_pkg::SUM_W'(state.fraction_accumulator);
    samples_raw = sum[ufpp_pkg::SUM_W-1:ufpp_pkg::FRAC_BITS];
    samples = (samples_raw == '0) ? ufpp_pkg::SMP_W'(1) : samples_raw;
    bytes = ufpp_pkg::BYTES_W'(samples) * ufpp_pkg::BYTES_W'(cfg.frame_size);
    oversize = (cfg.frame_size == '0) ||
               (32'(samples) > 32'(ufpp_pkg::SAMPLES_MAX)) ||
               (32'(bytes) > 32'(cfg.max_packet_len));
    short_in = 32'(bytes) > 32'(item.available_bytes);

    // lengths of 4 and above count as 4
    use_hs  = cfg.high_speed_mode && (item.feedback_length >= 3'd4);
    meas_hs = (ufpp_pkg::MEAS_W'(item.feedback_data) << ufpp_pkg::HS_SHL)
              >> ufpp_pkg::HS_SHR;
    meas_fs = (ufpp_pkg::MEAS_W'(item.feedback_data[23:0]) << ufpp_pkg::FS_SHL)
              >> ufpp_pkg::FS_SHR;
    measured = use_hs ? meas_hs : meas_fs;

    nom_ext = ufpp_pkg::EST_W'(cfg.nominal_rate);
    slack   = ufpp_pkg::EST_W'(1) << ufpp_pkg::FRAC_BITS;
    lo      = (nom_ext > slack) ? nom_ext - slack : ufpp_pkg::EST_W'(1);
    hi      = nom_ext + slack;
    if (measured < ufpp_pkg::MEAS_W'(lo)) begin
      clamped = lo;
    end else if (measured > ufpp_pkg::MEAS_W'(hi)) begin
      clamped = hi;
    end else begin
      clamped = measured[ufpp_pkg::EST_W-1:0];
    end
    blend = (ufpp_pkg::EST_W+3)'(state.rate_estimate) * (ufpp_pkg::EST_W+3)'(3) +
            (ufpp_pkg::EST_W+3)'(clamped);

    state_nxt             = state;
    result.packet_samples = '0;
    result.packet_len     = '0;
    result.status         = ufpp_pkg::ST_FB_IGNORED;

    case (item.command)
      ufpp_pkg::CMD_PACKET: begin
        if (oversize) begin
          result.status = ufpp_pkg::ST_OVERSIZE;
        end else if (short_in) begin
          result.status = ufpp_pkg::ST_SHORT;
        end else begin
          state_nxt.fraction_accumulator = sum[ufpp_pkg::FRAC_BITS-1:0];
          result.packet_samples = ufpp_pkg::OUT_SMP_W'(samples);
          result.packet_len     = ufpp_pkg::OUT_BYTES_W'(bytes);
          result.status         = ufpp_pkg::ST_OK;
        end
      end
      ufpp_pkg::CMD_FEEDBACK: begin
        if ((item.feedback_length >= 3'd3) && (measured != '0)) begin
          state_nxt.rate_estimate = blend[ufpp_pkg::EST_W+1:2];
          result.status = ufpp_pkg::ST_FB_APPLIED;
        end
      end
      ufpp_pkg::CMD_RESTART: begin
        state_nxt.fraction_accumulator = '0;
        state_nxt.rate_estimate = nom_ext;
        result.status = ufpp_pkg::ST_RESTARTED;
      end
      default: begin
        result.status = ufpp_pkg::ST_FB_IGNORED;
      end
    endcase

    result.rate_estimate_out = state_nxt.rate_estimate;
  end

endmodule

FILE: src/usb_feedback_packet_pacer.sv
// Top level of the USB feedback packet pacer: config, input stage, state, result stage.
`timescale 1ns / 1ps
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    command, feedback_data, feedback_length,
//                                             available_bytes
//  out_     output     out_valid / out_ready  packet_samples, packet_len, status,
//                                             rate_estimate_out
//  cfg_     input      cfg_we (no wait)       cfg_index, cfg_wdata
//
//  Each transaction passes two registers: the input register, then the
//  step logic into the result register. A new transaction is taken every
//  cycle unless a stall has filled both; the pacing state updates as an
//  item moves into the result register, so items are handled strictly in
//  order. A stalled result holds the result register and, behind it, the
//  input register; in_ready drops only when both are full. Reset (synchronous,
//  active low) empties both stages and loads the register and state defaults.
module usb_feedback_packet_pacer (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 cfg_we,
  input  logic [ufpp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ufpp_pkg::CFG_DATA_W-1:0]      cfg_wdata,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ufpp_pkg::CMD_W-1:0]           in_command,
  input  logic [ufpp_pkg::FB_DATA_W-1:0]       in_feedback_data,
  input  logic [ufpp_pkg::FB_LEN_W-1:0]        in_feedback_length,
  input  logic [ufpp_pkg::AVAIL_W-1:0]         in_available_bytes,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ufpp_pkg::OUT_SMP_W-1:0]       out_packet_samples,
  output logic [ufpp_pkg::OUT_BYTES_W-1:0]     out_packet_len,
  output logic [ufpp_pkg::STATUS_W-1:0]        out_status,
  output logic [ufpp_pkg::EST_W-1:0]           out_rate_estimate_out
);

  ufpp_pkg::cfg_t    cfg_r;
  ufpp_pkg::state_t  state_r;
  ufpp_pkg::state_t  state_nxt;
  ufpp_pkg::item_t   item_r;
  ufpp_pkg::result_t result_r;
  ufpp_pkg::result_t result_nxt;
  logic              item_valid_r;
  logic              out_valid_r;
  logic              advance;
  logic              in_take;

  // Move the held item into the result register when that slot is free or draining.
  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  ufpp_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Configuration registers: write on enable, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nominal_rate     <= ufpp_pkg::NOM_RESET;
      cfg_r.high_speed_mode  <= 1'b0;
      cfg_r.frame_size       <= ufpp_pkg::BPF_RESET;
      cfg_r.max_packet_len   <= ufpp_pkg::MPB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ufpp_pkg::CFG_NOMINAL_RATE:    cfg_r.nominal_rate     <= cfg_wdata;
        ufpp_pkg::CFG_HIGH_SPEED_MODE: cfg_r.high_speed_mode  <= cfg_wdata[0];
        ufpp_pkg::CFG_FRAME_SIZE:
          cfg_r.frame_size <= cfg_wdata[ufpp_pkg::BPF_W-1:0];
        ufpp_pkg::CFG_MAX_PACKET:
          cfg_r.max_packet_len <= cfg_wdata[ufpp_pkg::MPB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pacing state: advance only as an item retires into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.fraction_accumulator <= '0;
      state_r.rate_estimate        <= ufpp_pkg::EST_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Input stage and result stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.command         <= in_command;
      item_r.feedback_data   <= in_feedback_data;
      item_r.feedback_length <= in_feedback_length;
      item_r.available_bytes <= in_available_bytes;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_packet_samples    = result_r.packet_samples;
  assign out_packet_len        = result_r.packet_len;
  assign out_status            = result_r.status;
  assign out_rate_estimate_out = result_r.rate_estimate_out;

endmodule
